// File: rtl/rtc_tse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rtc_tse_pkg;

  // operation codes
  typedef enum logic {
    OP_BEGIN = 1'b0,
    OP_KEY   = 1'b1
  } op_e;

  // key codes, the two unused codes act as no key
  typedef enum logic [2:0] {
    KEY_NONE   = 3'd0,
    KEY_UP     = 3'd1,
    KEY_DOWN   = 3'd2,
    KEY_NEXT   = 3'd3,
    KEY_PREV   = 3'd4,
    KEY_COMMIT = 3'd5
  } key_e;

  // field being edited
  typedef enum logic [1:0] {
    FLD_HOURS   = 2'd0,
    FLD_MINUTES = 2'd1,
    FLD_SECONDS = 2'd2
  } field_e;

  localparam logic [7:0] HoursMax     = 8'd23;
  localparam logic [7:0] MinSecMax    = 8'd59;
  localparam logic [7:0] HoursBcdMask = 8'hBF;

  // one result beat
  typedef struct packed {
    logic [5:0] hours_now;
    logic [7:0] minutes_now;
    logic [7:0] seconds_now;
    logic [1:0] field_selected;
    logic       editor_active;
    logic       commit_strobe;
    logic [7:0] hours_bcd_out;
    logic [7:0] minutes_bcd_out;
    logic [7:0] seconds_bcd_out;
  } res_t;

  // bcd hours to binary, tens digit masked to two bits
  function automatic logic [5:0] hours_to_bin(input logic [7:0] h);
    logic [5:0] tens;
    tens = {4'd0, h[5:4]};
    return 6'((tens << 3) + (tens << 1) + {2'd0, h[3:0]});
  endfunction

  // bcd byte to binary, no digit check
  function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
    logic [7:0] tens;
    tens = {4'd0, v[7:4]};
    return 8'((tens << 3) + (tens << 1) + {4'd0, v[3:0]});
  endfunction

  // binary to bcd, divide by ten through a reciprocal multiply
  function automatic logic [7:0] bin_to_bcd(input logic [7:0] v);
    logic [15:0] prod;
    logic [4:0]  quo;
    logic [7:0]  rem;
    prod = 16'(v) * 16'd205;
    quo  = prod[15:11];
    rem  = 8'(v - 8'(quo) * 8'd10);
    return {quo[3:0], rem[3:0]};
  endfunction

  // up wraps to zero above the limit, down from zero wraps to the limit
  function automatic logic [7:0] step_value(input logic [7:0] v, input logic [2:0] key,
                                            input logic [7:0] limit);
    logic [7:0] nxt;
    nxt = v;
    if (key == KEY_UP) begin
      nxt = 8'(v + 8'd1);
      if (nxt > limit) begin
        nxt = 8'd0;
      end
    end else if (key == KEY_DOWN) begin
      if (v == 8'd0) begin
        nxt = limit;
      end else begin
        nxt = 8'(v - 8'd1);
      end
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

// File: rtl/rtc_time_set_editor_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel | direction | handshake              | payload
// in      | input     | in_valid_i / in_stall_o   | operation, clock bcd bytes, key_code
// out     | output    | out_valid_o / out_stall_i | binary values, field, flags, bcd bytes
//
// one beat a cycle while in_stall_o is low: the edit state and the result are updated in the accept cycle,
// and the result is registered in the result register, or in the skid register while out_stall_i holds it.
// a two-entry output buffer (result register plus skid register) parts the sides;
// in_stall_o rises only when both entries are full.
// reset clears the edit state (hours field, inactive) and the valid flags of both buffer entries.

module rtc_time_set_editor_core
  import rtc_tse_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       operation_i,
  input  wire logic [7:0] clock_hours_bcd_i,
  input  wire logic [7:0] clock_minutes_bcd_i,
  input  wire logic [7:0] clock_seconds_bcd_i,
  input  wire logic [2:0] key_code_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [5:0]      hours_now_o,
  output logic [7:0]      minutes_now_o,
  output logic [7:0]      seconds_now_o,
  output logic [1:0]      field_selected_o,
  output logic            editor_active_o,
  output logic            commit_strobe_o,
  output logic [7:0]      hours_bcd_out_o,
  output logic [7:0]      minutes_bcd_out_o,
  output logic [7:0]      seconds_bcd_out_o
);

  logic [5:0] hours_q,   hours_d;
  logic [7:0] minutes_q, minutes_d;
  logic [7:0] seconds_q, seconds_d;
  field_e     field_q,   field_d;
  logic       active_q,  active_d;

  res_t res;
  res_t out_q, out_d;
  res_t skd_q, skd_d;
  logic out_vld_q, out_vld_d;
  logic skd_vld_q, skd_vld_d;

  logic in_acc;
  logic out_take;

  assign in_stall_o = skd_vld_q;
  assign in_acc     = in_valid_i & ~skd_vld_q;
  assign out_take   = out_vld_q & ~out_stall_i;

  // edit state update and result for one beat
  always_comb begin
    hours_d   = hours_q;
    minutes_d = minutes_q;
    seconds_d = seconds_q;
    field_d   = field_q;
    active_d  = active_q;
    res       = '0;
    if (operation_i == OP_BEGIN) begin
      hours_d   = hours_to_bin(clock_hours_bcd_i);
      minutes_d = bcd_to_bin(clock_minutes_bcd_i);
      seconds_d = bcd_to_bin(clock_seconds_bcd_i);
      field_d   = FLD_HOURS;
      active_d  = 1'b1;
    end else if (active_q) begin
      unique case (key_code_i)
        KEY_NEXT: begin
          if (field_q != FLD_SECONDS) begin
            field_d = field_e'(field_q + 2'd1);
          end
        end
        KEY_PREV: begin
          if (field_q != FLD_HOURS) begin
            field_d = field_e'(field_q - 2'd1);
          end
        end
        KEY_COMMIT: begin
          res.commit_strobe   = 1'b1;
          res.hours_bcd_out   = bin_to_bcd({2'd0, hours_q}) & HoursBcdMask;
          res.minutes_bcd_out = bin_to_bcd(minutes_q);
          res.seconds_bcd_out = bin_to_bcd(seconds_q);
          active_d            = 1'b0;
        end
        default: begin
          unique case (field_q)
            FLD_HOURS: begin
              hours_d = 6'(step_value({2'd0, hours_q}, key_code_i, HoursMax));
            end
            FLD_MINUTES: begin
              minutes_d = step_value(minutes_q, key_code_i, MinSecMax);
            end
            default: begin
              seconds_d = step_value(seconds_q, key_code_i, MinSecMax);
            end
          endcase
        end
      endcase
    end
    res.hours_now      = hours_d;
    res.minutes_now    = minutes_d;
    res.seconds_now    = seconds_d;
    res.field_selected = field_d;
    res.editor_active  = active_d;
  end

  // edit state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hours_q   <= '0;
      minutes_q <= '0;
      seconds_q <= '0;
      field_q   <= FLD_HOURS;
      active_q  <= 1'b0;
    end else if (in_acc) begin
      hours_q   <= hours_d;
      minutes_q <= minutes_d;
      seconds_q <= seconds_d;
      field_q   <= field_d;
      active_q  <= active_d;
    end
  end

  // output buffer: result register with a skid entry behind it
  always_comb begin
    out_d     = out_q;
    skd_d     = skd_q;
    out_vld_d = out_vld_q;
    skd_vld_d = skd_vld_q;
    if (out_take || !out_vld_q) begin
      if (skd_vld_q) begin
        out_d     = skd_q;
        out_vld_d = 1'b1;
        skd_vld_d = 1'b0;
      end else begin
        out_d     = res;
        out_vld_d = in_acc;
      end
    end else if (in_acc) begin
      skd_d     = res;
      skd_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      skd_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      skd_vld_q <= skd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    skd_q <= skd_d;
  end

  assign out_valid_o       = out_vld_q;
  assign hours_now_o       = out_q.hours_now;
  assign minutes_now_o     = out_q.minutes_now;
  assign seconds_now_o     = out_q.seconds_now;
  assign field_selected_o  = out_q.field_selected;
  assign editor_active_o   = out_q.editor_active;
  assign commit_strobe_o   = out_q.commit_strobe;
  assign hours_bcd_out_o   = out_q.hours_bcd_out;
  assign minutes_bcd_out_o = out_q.minutes_bcd_out;
  assign seconds_bcd_out_o = out_q.seconds_bcd_out;

endmodule

`default_nettype wire

// File: rtl/rtc_tse_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rtc_tse_checker
  import rtc_tse_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [1:0] field_selected_o,
  input wire logic       editor_active_o,
  input wire logic       commit_strobe_o,
  input wire logic [7:0] hours_bcd_out_o,
  input wire logic [7:0] minutes_bcd_out_o,
  input wire logic [7:0] seconds_bcd_out_o
);

  // a commit beat always closes the session
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && commit_strobe_o) |-> !editor_active_o)
    else $error("commit beat with session still open");

  // bcd bytes stay zero on beats without a commit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !commit_strobe_o) |->
      (hours_bcd_out_o == 8'd0 && minutes_bcd_out_o == 8'd0 && seconds_bcd_out_o == 8'd0))
    else $error("bcd bytes set without commit");

  // 24-hour mode bit is always cleared on commit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && commit_strobe_o) |-> !hours_bcd_out_o[6])
    else $error("hours bit 6 set on commit");

  // field select never leaves the three fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (field_selected_o == FLD_HOURS || field_selected_o == FLD_MINUTES ||
                     field_selected_o == FLD_SECONDS))
    else $error("field select out of range");

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(commit_strobe_o) && $stable(field_selected_o)))
    else $error("stalled result beat changed");

endmodule

bind rtc_time_set_editor_core rtc_tse_checker u_rtc_tse_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .field_selected_o  (field_selected_o),
  .editor_active_o   (editor_active_o),
  .commit_strobe_o   (commit_strobe_o),
  .hours_bcd_out_o   (hours_bcd_out_o),
  .minutes_bcd_out_o (minutes_bcd_out_o),
  .seconds_bcd_out_o (seconds_bcd_out_o)
);

`default_nettype wire
